>>> rtl/pfge_pkg.sv
package pfge_pkg;

  // Store geometry.
  localparam int COLUMNS    = 128;
  localparam int ROWS       = 64;
  localparam int PAGE_COUNT = 8;
  localparam int DEPTH      = COLUMNS * PAGE_COUNT;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PG_W       = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

  // Glyph geometry.
  localparam int GLYPH_W = 5;
  localparam int COL_W   = 3;

  localparam logic [7:0] BYTE_ON  = 8'hFF;
  localparam logic [7:0] BYTE_OFF = 8'h00;

  typedef enum logic [1:0] {
    OP_FILL  = 2'd0,
    OP_PIXEL = 2'd1,
    OP_GLYPH = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // Column 0 of a glyph sits at index 0.
  typedef logic [0:GLYPH_W-1][7:0] glyph_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;     // take the input beat into the command registers
    logic cnt_clr;     // zero the sweep and column counter
    logic cnt_inc;     // advance the counter
    logic sweep_wr;    // write the swept byte
    logic sweep_ones;  // swept byte follows the fill level, else zero
    logic mem_rd;      // read the byte at the command address
    logic pix_wr;      // write back the modified pixel byte
    logic glyph_wr;    // write one glyph column
    logic load_out;    // load the result register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    op_t  op;
    logic in_range;
    logic cnt_last;
    logic col_last;
  } status_t;

  // 5x7 font lookup; codes outside the font draw blank columns.
  function automatic glyph_t font_glyph(input logic [7:0] code);
    glyph_t g;
    case (code)
      "0":     g = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
      "1":     g = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
      "2":     g = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
      "3":     g = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
      "4":     g = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
      "5":     g = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
      "6":     g = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
      "7":     g = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
      "8":     g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      "9":     g = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
      " ":     g = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      "-":     g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
      ".":     g = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
      "%":     g = {8'h26, 8'h49, 8'h49, 8'h29, 8'h11};
      "C":     g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
      "H":     g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
      "e":     g = {8'h38, 8'h54, 8'h54, 8'h54, 8'h18};
      "p":     g = {8'h7C, 8'h12, 8'h12, 8'h12, 8'h0C};
      "m":     g = {8'h44, 8'h6D, 8'h55, 8'h55, 8'h44};
      "E":     g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
      "r":     g = {8'h7C, 8'h08, 8'h04, 8'h04, 8'h08};
      "o":     g = {8'h38, 8'h44, 8'h44, 8'h44, 8'h38};
      "T":     g = {8'h01, 8'h7F, 8'h01, 8'h01, 8'h01};
      ":":     g = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
      "/":     g = {8'h40, 8'h30, 8'h08, 8'h06, 8'h01};
      "A":     g = {8'h7C, 8'h12, 8'h11, 8'h12, 8'h7C};
      "B":     g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
      "D":     g = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
      "K":     g = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
      "P":     g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
      "R":     g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h0E};
      "S":     g = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
      "O":     g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
      "V":     g = {8'h1E, 8'h21, 8'h21, 8'h12, 8'h0C};
      "W":     g = {8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F};
      "N":     g = {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
      "I":     g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
      "F":     g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
      "U":     g = {8'h3E, 8'h41, 8'h41, 8'h22, 8'h1C};
      "G":     g = {8'h3E, 8'h41, 8'h49, 8'h49, 8'h3A};
      "L":     g = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
      "b":     g = {8'h7F, 8'h48, 8'h44, 8'h44, 8'h38};
      "y":     g = {8'h08, 8'h14, 8'h62, 8'h02, 8'h02};
      "k":     g = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

>>> rtl/pfge_in_if.sv
interface pfge_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] x_pos;
  logic [7:0] y_pos;
  logic [7:0] page_index;
  logic       pixel_on;
  logic [7:0] char_code;

  modport source (
    output valid, op, x_pos, y_pos, page_index, pixel_on, char_code,
    input  ready
  );
  modport sink (
    input  valid, op, x_pos, y_pos, page_index, pixel_on, char_code,
    output ready
  );
endinterface

>>> rtl/pfge_out_if.sv
interface pfge_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       applied;

  modport source (
    output valid, read_data, applied,
    input  ready
  );
  modport sink (
    input  valid, read_data, applied,
    output ready
  );
endinterface

>>> rtl/pfge_datapath.sv
module pfge_datapath (
  input  logic              clk,
  input  pfge_pkg::cmd_t    cmd,
  output pfge_pkg::status_t status,
  input  logic [1:0]        in_op,
  input  logic [7:0]        in_x_pos,
  input  logic [7:0]        in_y_pos,
  input  logic [7:0]        in_page_index,
  input  logic              in_pixel_on,
  input  logic [7:0]        in_char_code,
  input  logic              rst_n,
  output logic [7:0]        out_read_data,
  output logic              out_applied
);

  // Frame store: one byte per page column, bit 0 on top.
  logic [7:0] store_mem [pfge_pkg::DEPTH];
  logic [7:0] rd_data_r;

  // Command registers.
  pfge_pkg::op_t op_r;
  logic [7:0]    x_r;
  logic [7:0]    y_r;
  logic [7:0]    page_r;
  logic          on_r;
  logic [7:0]    code_r;

  // Result register.
  logic [7:0] read_data_r;
  logic       applied_r;

  // Sweep address, also the glyph column in its low bits.
  logic [pfge_pkg::ADDR_W-1:0] cnt_r;
  logic [pfge_pkg::ADDR_W-1:0] cnt_nxt;

  logic                        x_ok;
  logic                        pix_ok;
  logic                        glyph_ok;
  logic                        read_ok;
  logic                        in_range;
  logic [pfge_pkg::PG_W-1:0]   pg;
  logic [pfge_pkg::ADDR_W-1:0] base;
  logic [pfge_pkg::ADDR_W-1:0] addr;
  logic [pfge_pkg::COL_W-1:0]  col;
  logic [7:0]                  mask;
  logic [7:0]                  wdata;
  logic                        we;
  pfge_pkg::glyph_t            glyph;

  // Capture the accepted beat.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= pfge_pkg::op_t'(in_op);
      x_r    <= in_x_pos;
      y_r    <= in_y_pos;
      page_r <= in_page_index;
      on_r   <= in_pixel_on;
      code_r <= in_char_code;
    end
  end

  // Range checks on the held command.
  always_comb begin
    x_ok     = {1'b0, x_r} < 9'(pfge_pkg::COLUMNS);
    pix_ok   = x_ok && ({1'b0, y_r} < 9'(pfge_pkg::ROWS))
               && ({1'b0, (y_r >> 3)} < 9'(pfge_pkg::PAGE_COUNT));
    glyph_ok = ({1'b0, page_r} < 9'(pfge_pkg::PAGE_COUNT))
               && ({1'b0, x_r} + 9'(pfge_pkg::GLYPH_W) <= 9'(pfge_pkg::COLUMNS));
    read_ok  = x_ok && ({1'b0, page_r} < 9'(pfge_pkg::PAGE_COUNT));
    case (op_r)
      pfge_pkg::OP_FILL:  in_range = 1'b1;
      pfge_pkg::OP_PIXEL: in_range = pix_ok;
      pfge_pkg::OP_GLYPH: in_range = glyph_ok;
      pfge_pkg::OP_READ:  in_range = read_ok;
      default:            in_range = 1'b0;
    endcase
  end

  // Sweep and column counter.
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign col = cnt_r[pfge_pkg::COL_W-1:0];

  // Store address: page row base plus column (plus the glyph column on glyph writes), or the sweep position.
  always_comb begin
    if (op_r == pfge_pkg::OP_PIXEL) begin
      pg = pfge_pkg::PG_W'(y_r >> 3);
    end else begin
      pg = pfge_pkg::PG_W'(page_r);
    end
    base = pfge_pkg::ADDR_W'(pg) * pfge_pkg::ADDR_W'(pfge_pkg::COLUMNS)
           + pfge_pkg::ADDR_W'(x_r);
    if (cmd.sweep_wr) begin
      addr = cnt_r;
    end else if (cmd.glyph_wr) begin
      addr = base + pfge_pkg::ADDR_W'(col);
    end else begin
      addr = base;
    end
  end

  // Write data for the three kinds of store write.
  always_comb begin
    glyph = pfge_pkg::font_glyph(code_r);
    mask  = 8'd1 << y_r[2:0];
    we    = cmd.sweep_wr | cmd.pix_wr | cmd.glyph_wr;
    if (cmd.sweep_wr) begin
      wdata = (cmd.sweep_ones && on_r) ? pfge_pkg::BYTE_ON : pfge_pkg::BYTE_OFF;
    end else if (cmd.glyph_wr) begin
      wdata = glyph[col];
    end else if (on_r) begin
      wdata = rd_data_r | mask;
    end else begin
      wdata = rd_data_r & ~mask;
    end
  end

  // Single-port store with registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      store_mem[addr] <= wdata;
    end
    if (cmd.mem_rd) begin
      rd_data_r <= store_mem[addr];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      applied_r   <= in_range;
      read_data_r <= (op_r == pfge_pkg::OP_READ && in_range) ? rd_data_r : 8'h00;
    end
  end

  assign out_read_data = read_data_r;
  assign out_applied   = applied_r;

  assign status.op       = op_r;
  assign status.in_range = in_range;
  assign status.cnt_last = cnt_r == pfge_pkg::ADDR_W'(pfge_pkg::DEPTH - 1);
  assign status.col_last = col == pfge_pkg::COL_W'(pfge_pkg::GLYPH_W - 1);

endmodule

>>> rtl/pfge_ctrl.sv
module pfge_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pfge_pkg::status_t status,
  output pfge_pkg::cmd_t    cmd
);

  typedef enum logic [8:0] {
    ST_CLEAR    = 9'b000000001,
    ST_IDLE     = 9'b000000010,
    ST_DISPATCH = 9'b000000100,
    ST_FILL     = 9'b000001000,
    ST_PIX_RD   = 9'b000010000,
    ST_PIX_WR   = 9'b000100000,
    ST_GLYPH    = 9'b001000000,
    ST_READ     = 9'b010000000,
    ST_DONE     = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  // Next state and datapath commands.
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_CLEAR: begin
        cmd.sweep_wr = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (status.cnt_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.cnt_clr = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (!status.in_range) begin
          state_nxt = ST_DONE;
        end else begin
          case (status.op)
            pfge_pkg::OP_FILL:  state_nxt = ST_FILL;
            pfge_pkg::OP_PIXEL: state_nxt = ST_PIX_RD;
            pfge_pkg::OP_GLYPH: state_nxt = ST_GLYPH;
            pfge_pkg::OP_READ:  state_nxt = ST_READ;
            default:            state_nxt = ST_DONE;
          endcase
        end
      end
      ST_FILL: begin
        cmd.sweep_wr   = 1'b1;
        cmd.sweep_ones = 1'b1;
        cmd.cnt_inc    = 1'b1;
        if (status.cnt_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_PIX_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_PIX_WR;
      end
      ST_PIX_WR: begin
        cmd.pix_wr = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_GLYPH: begin
        cmd.glyph_wr = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (status.col_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        // Hand the result over once the output register is free.
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/page_framebuffer_glyph_engine.sv
// Page-organized monochrome frame store (COLUMNS x PAGE_COUNT bytes, each byte
// eight vertical pixels with bit 0 on top) with fill, pixel set/clear, 5x7
// glyph write and byte read commands; every command beat returns one result
// beat. After reset the block sweeps the store to zero, one byte a cycle, over
// all COLUMNS*PAGE_COUNT (1024) bytes before it takes the first command. All
// work goes through one single-port store with a registered read, one access
// per cycle, and one command is in flight at a time. After the accepted beat
// a command passes a dispatch state, its work (read; pixel read then write;
// one glyph write per column; fill sweep; none if out of range) and a done
// state. A new command is taken while the previous result still waits in
// the output register.
module page_framebuffer_glyph_engine (
  input logic       clk,
  input logic       rst_n,
  pfge_in_if.sink   in_bus,
  pfge_out_if.source out_bus
);

  pfge_pkg::cmd_t    cmd;
  pfge_pkg::status_t status;

  // Sequencer.
  pfge_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Store, address and data path.
  pfge_datapath u_datapath (
    .clk           (clk),
    .cmd           (cmd),
    .status        (status),
    .in_op         (in_bus.op),
    .in_x_pos      (in_bus.x_pos),
    .in_y_pos      (in_bus.y_pos),
    .in_page_index (in_bus.page_index),
    .in_pixel_on   (in_bus.pixel_on),
    .in_char_code  (in_bus.char_code),
    .rst_n         (rst_n),
    .out_read_data (out_bus.read_data),
    .out_applied   (out_bus.applied)
  );

endmodule

>>> test/page_framebuffer_glyph_engine_tb.sv
`timescale 1ns / 100ps

module page_framebuffer_glyph_engine_tb;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_CMDS  = 575;
  localparam int DIRECTED_CMDS = 25;
  localparam int FONT_ENTRIES = 44;
  localparam int IDLE_PCT     = 19;

  // Store geometry taken from the package.
  localparam int COLUMNS    = pfge_pkg::COLUMNS;
  localparam int ROWS       = pfge_pkg::ROWS;
  localparam int PAGE_COUNT = pfge_pkg::PAGE_COUNT;
  localparam int DEPTH      = pfge_pkg::DEPTH;
  localparam int GLYPH_W    = pfge_pkg::GLYPH_W;

  typedef struct packed {
    pfge_pkg::op_t op;
    logic [7:0]    x_pos;
    logic [7:0]    y_pos;
    logic [7:0]    page_index;
    logic          pixel_on;
    logic [7:0]    char_code;
  } command_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       applied;
  } response_t;

  // One directed row: the command, and a typed response where it is obvious.
  typedef struct packed {
    command_t  cmd;
    logic      typed;
    response_t resp;
  } directed_row_t;

  logic clk;
  logic rst_n;

  pfge_in_if  in_ch ();
  pfge_out_if out_ch ();

  page_framebuffer_glyph_engine u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_ch.sink),
    .out_bus(out_ch.source)
  );

  // Font entries: character code, then columns left to right.
  logic [47:0] font_rows [FONT_ENTRIES] = '{
    48'h30_3E_51_49_45_3E, 48'h31_00_42_7F_40_00, 48'h32_42_61_51_49_46,
    48'h33_21_41_45_4B_31, 48'h34_18_14_12_7F_10, 48'h35_27_45_45_45_39,
    48'h36_3C_4A_49_49_30, 48'h37_01_71_09_05_03, 48'h38_36_49_49_49_36,
    48'h39_06_49_49_29_1E, 48'h20_00_00_00_00_00, 48'h2D_08_08_08_08_08,
    48'h2E_00_60_60_00_00, 48'h25_26_49_49_29_11, 48'h43_3E_41_41_41_22,
    48'h48_7F_08_08_08_7F, 48'h65_38_54_54_54_18, 48'h70_7C_12_12_12_0C,
    48'h6D_44_6D_55_55_44, 48'h45_7F_49_49_49_41, 48'h72_7C_08_04_04_08,
    48'h6F_38_44_44_44_38, 48'h54_01_7F_01_01_01, 48'h3A_00_36_36_00_00,
    48'h2F_40_30_08_06_01, 48'h41_7C_12_11_12_7C, 48'h42_7F_49_49_49_36,
    48'h44_7F_41_41_22_1C, 48'h4B_7F_08_14_22_41, 48'h50_7F_09_09_09_06,
    48'h52_7E_11_11_11_0E, 48'h53_46_49_49_49_31, 48'h4F_3E_41_41_41_3E,
    48'h56_1E_21_21_12_0C, 48'h57_7F_20_18_20_7F, 48'h4E_7F_04_08_10_7F,
    48'h49_00_41_7F_41_00, 48'h46_7F_09_09_09_01, 48'h55_3E_41_41_22_1C,
    48'h47_3E_41_49_49_3A, 48'h4C_7F_40_40_40_40, 48'h62_7F_48_44_44_38,
    48'h79_08_14_62_02_02, 48'h6B_7F_08_14_22_41
  };

  // Directed commands: reads after reset, range edges, fill, glyph overrun,
  // unmapped code and the cleared top bit of glyph bytes.
  directed_row_t directed_rows [DIRECTED_CMDS] = '{
    '{'{pfge_pkg::OP_READ,  8'd0,   8'd0,   8'd0,   1'b0, 8'h00}, 1'b1, '{8'h00, 1'b1}},
    '{'{pfge_pkg::OP_READ,  8'd127, 8'd0,   8'd7,   1'b0, 8'h00}, 1'b1, '{8'h00, 1'b1}},
    '{'{pfge_pkg::OP_READ,  8'd128, 8'd0,   8'd0,   1'b0, 8'h00}, 1'b1, '{8'h00, 1'b0}},
    '{'{pfge_pkg::OP_READ,  8'd0,   8'd0,   8'd8,   1'b0, 8'h00}, 1'b1, '{8'h00, 1'b0}},
    '{'{pfge_pkg::OP_READ,  8'd255, 8'd255, 8'd255, 1'b1, 8'hFF}, 1'b1, '{8'h00, 1'b0}},
    '{'{pfge_pkg::OP_FILL,  8'd255, 8'd255, 8'd255, 1'b1, 8'hFF}, 1'b1, '{8'h00, 1'b1}},
    '{'{pfge_pkg::OP_READ,  8'd127, 8'd0,   8'd7,   1'b0, 8'h00}, 1'b1, '{8'hFF, 1'b1}},
    '{'{pfge_pkg::OP_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, 8'h00}, 1'b1, '{8'h00, 1'b1}},
    '{'{pfge_pkg::OP_READ,  8'd0,   8'd0,   8'd0,   1'b0, 8'h00}, 1'b1, '{8'hFE, 1'b1}},
    '{'{pfge_pkg::OP_PIXEL, 8'd127, 8'd63,  8'd0,   1'b0, 8'h00}, 1'b1, '{8'h00, 1'b1}},
    '{'{pfge_pkg::OP_READ,  8'd127, 8'd0,   8'd7,   1'b0, 8'h00}, 1'b1, '{8'h7F, 1'b1}},
    '{'{pfge_pkg::OP_PIXEL, 8'd128, 8'd0,   8'd0,   1'b1, 8'h00}, 1'b1, '{8'h00, 1'b0}},
    '{'{pfge_pkg::OP_PIXEL, 8'd0,   8'd64,  8'd0,   1'b1, 8'h00}, 1'b1, '{8'h00, 1'b0}},
    '{'{pfge_pkg::OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b1, 8'hFF}, 1'b1, '{8'h00, 1'b0}},
    '{'{pfge_pkg::OP_GLYPH, 8'd0,   8'd0,   8'd0,   1'b1, 8'h30}, 1'b1, '{8'h00, 1'b1}},
    '{'{pfge_pkg::OP_READ,  8'd0,   8'd0,   8'd0,   1'b0, 8'h00}, 1'b1, '{8'h3E, 1'b1}},
    '{'{pfge_pkg::OP_GLYPH, 8'd123, 8'd0,   8'd7,   1'b0, 8'h48}, 1'b1, '{8'h00, 1'b1}},
    '{'{pfge_pkg::OP_READ,  8'd127, 8'd0,   8'd7,   1'b0, 8'h00}, 1'b1, '{8'h7F, 1'b1}},
    '{'{pfge_pkg::OP_GLYPH, 8'd124, 8'd0,   8'd0,   1'b1, 8'h41}, 1'b1, '{8'h00, 1'b0}},
    '{'{pfge_pkg::OP_GLYPH, 8'd0,   8'd0,   8'd8,   1'b1, 8'h41}, 1'b1, '{8'h00, 1'b0}},
    '{'{pfge_pkg::OP_GLYPH, 8'd10,  8'd0,   8'd3,   1'b1, 8'hFF}, 1'b1, '{8'h00, 1'b1}},
    '{'{pfge_pkg::OP_READ,  8'd12,  8'd0,   8'd3,   1'b0, 8'h00}, 1'b1, '{8'h00, 1'b1}},
    '{'{pfge_pkg::OP_PIXEL, 8'd12,  8'd31,  8'd0,   1'b1, 8'h00}, 1'b1, '{8'h00, 1'b1}},
    '{'{pfge_pkg::OP_READ,  8'd12,  8'd0,   8'd3,   1'b0, 8'h00}, 1'b1, '{8'h80, 1'b1}},
    '{'{pfge_pkg::OP_FILL,  8'd0,   8'd0,   8'd0,   1'b0, 8'h00}, 1'b0, '{8'h00, 1'b0}}
  };

  logic [7:0] frame_bytes [DEPTH];
  response_t  pending_results [$];
  int         error_count = 0;
  int         cycle_count = 0;
  bit         steady_run  = 1'b0;
  logic [7:0] last_x      = '0;
  logic [7:0] last_page   = '0;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Applies one command to the shadow frame store and returns its response.
  function automatic response_t apply_to_frame(input command_t c);
    response_t  r;
    logic [7:0] mask;
    logic [39:0] cols;
    int         idx;
    r    = '0;
    cols = '0;
    case (c.op)
      pfge_pkg::OP_FILL: begin
        foreach (frame_bytes[i]) begin
          frame_bytes[i] = c.pixel_on ? pfge_pkg::BYTE_ON : pfge_pkg::BYTE_OFF;
        end
        r.applied = 1'b1;
      end
      pfge_pkg::OP_PIXEL: begin
        if (c.x_pos < COLUMNS && c.y_pos < ROWS && (c.y_pos >> 3) < PAGE_COUNT) begin
          idx  = int'(c.y_pos >> 3) * COLUMNS + int'(c.x_pos);
          mask = 8'h01 << c.y_pos[2:0];
          frame_bytes[idx] = c.pixel_on ? (frame_bytes[idx] | mask)
                                        : (frame_bytes[idx] & ~mask);
          r.applied = 1'b1;
        end
      end
      pfge_pkg::OP_GLYPH: begin
        if (c.page_index < PAGE_COUNT && int'(c.x_pos) + GLYPH_W <= COLUMNS) begin
          // Codes missing from the font draw five blank columns.
          for (int i = 0; i < FONT_ENTRIES; i++) begin
            if (font_rows[i][47:40] == c.char_code) cols = font_rows[i][39:0];
          end
          idx = int'(c.page_index) * COLUMNS + int'(c.x_pos);
          for (int k = 0; k < GLYPH_W; k++) frame_bytes[idx + k] = cols[39 - 8 * k -: 8];
          r.applied = 1'b1;
        end
      end
      default: begin
        if (c.x_pos < COLUMNS && c.page_index < PAGE_COUNT) begin
          r.read_data = frame_bytes[int'(c.page_index) * COLUMNS + int'(c.x_pos)];
          r.applied   = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  // Drives one command beat from a falling edge and records its response.
  task automatic send_command(input command_t c, input logic typed, input response_t resp);
    response_t r;
    while (!steady_run && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.op         = c.op;
    in_ch.x_pos      = c.x_pos;
    in_ch.y_pos      = c.y_pos;
    in_ch.page_index = c.page_index;
    in_ch.pixel_on   = c.pixel_on;
    in_ch.char_code  = c.char_code;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = apply_to_frame(c);
    pending_results.push_back(typed ? resp : r);
    @(negedge clk);
  endtask

  // Stimulus: reset, directed commands, then random traffic.
  initial begin
    command_t c;
    int       sel;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.op         = pfge_pkg::OP_FILL;
    in_ch.x_pos      = '0;
    in_ch.y_pos      = '0;
    in_ch.page_index = '0;
    in_ch.pixel_on   = 1'b0;
    in_ch.char_code  = '0;
    foreach (frame_bytes[i]) frame_bytes[i] = pfge_pkg::BYTE_OFF;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      send_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].resp);
    end

    for (int n = 0; n < RANDOM_CMDS; n++) begin
      steady_run = (n >= 200 && n < 320);
      sel = $urandom_range(0, 99);
      if (sel < 2) c.op = pfge_pkg::OP_FILL;
      else if (sel < 40) c.op = pfge_pkg::OP_PIXEL;
      else if (sel < 65) c.op = pfge_pkg::OP_GLYPH;
      else c.op = pfge_pkg::OP_READ;

      // Mostly in range, with a tenth of each coordinate over the full field.
      c.x_pos = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, COLUMNS - 1));
      c.y_pos = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, ROWS - 1));
      c.page_index = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, PAGE_COUNT - 1));
      c.pixel_on  = 1'($urandom_range(0, 1));
      c.char_code = ($urandom_range(0, 9) < 7)
                    ? font_rows[$urandom_range(0, FONT_ENTRIES - 1)][47:40]
                    : 8'($urandom_range(0, 255));

      // Keep glyphs inside the row most of the time, and aim many reads and
      // pixels at the spot last drawn so that writes get read back.
      if (c.op == pfge_pkg::OP_GLYPH && $urandom_range(0, 9) != 0) begin
        c.x_pos = 8'($urandom_range(0, COLUMNS - GLYPH_W));
      end
      if (c.op == pfge_pkg::OP_READ && $urandom_range(0, 1) == 1) begin
        c.x_pos      = last_x + 8'($urandom_range(0, GLYPH_W - 1));
        c.page_index = last_page;
      end
      if (c.op == pfge_pkg::OP_PIXEL && $urandom_range(0, 9) < 3) begin
        c.x_pos = last_x + 8'($urandom_range(0, GLYPH_W - 1));
        c.y_pos = {last_page[4:0], 3'($urandom_range(0, 7))};
      end
      if (c.op == pfge_pkg::OP_GLYPH && c.x_pos < COLUMNS && c.page_index < PAGE_COUNT) begin
        last_x    = c.x_pos;
        last_page = c.page_index;
      end
      if (c.op == pfge_pkg::OP_PIXEL && c.x_pos < COLUMNS && c.y_pos < ROWS) begin
        last_x    = c.x_pos;
        last_page = c.y_pos >> 3;
      end

      send_command(c, 1'b0, '0);
    end
    in_ch.valid = 1'b0;
    steady_run  = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result side backpressure, changed on the falling edge.
  always @(negedge clk) begin
    out_ch.ready = steady_run || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Compare each result beat with the oldest expected response.
  always @(posedge clk) begin
    response_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no command outstanding");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.read_data !== want.read_data) begin
          $error("read_data: expected %02h, got %02h", want.read_data, out_ch.read_data);
          error_count++;
        end
        if (out_ch.applied !== want.applied) begin
          $error("applied: expected %0b, got %0b", want.applied, out_ch.applied);
          error_count++;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

>>> page_framebuffer_glyph_engine.f
rtl/pfge_pkg.sv
rtl/pfge_in_if.sv
rtl/pfge_out_if.sv
rtl/pfge_datapath.sv
rtl/pfge_ctrl.sv
rtl/page_framebuffer_glyph_engine.sv
test/page_framebuffer_glyph_engine_tb.sv
